[rtl/blpg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bresenham line pixel generator package
// Shared widths, command codes and the records that move between the parts
// of the line pixel generator.
// ----------------------------------------------------------------------------
package blpg_pkg;

  // Coordinate and color widths.
  localparam int COORD_BITS = 10;
  localparam int COLOR_BITS = 8;

  // Command queue between the front and the back part.
  localparam int QDEPTH     = 4;
  localparam int QPTR_BITS  = $clog2(QDEPTH);
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

  // Result buffer in the back part.
  localparam int OBDEPTH     = 2;
  localparam int OB_PTR_BITS = $clog2(OBDEPTH);
  localparam int OB_CNT_BITS = $clog2(OBDEPTH + 1);

  // Bound on the step items that can be inside the block at once:
  // the front stage, the command queue and the result buffer.
  localparam int INFLIGHT_MAX  = QDEPTH + OBDEPTH + 1;
  localparam int INFLIGHT_BITS = $clog2(INFLIGHT_MAX + 1);

  // Request codes on the req_type input.
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COLOR_BITS-1:0] color_t;

  // Command kind carried through the queue.
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_kind_t;

  // Prepared command. For a start, the line set up in major/minor axes.
  typedef struct packed {
    cmd_kind_t kind;
    logic      steep;
    coord_t    major_pos;
    coord_t    major_end;
    coord_t    minor_pos;
    coord_t    minor_delta;
    coord_t    diff_delta;   // major delta minus minor delta
    coord_t    error;        // half the major delta, rounded down
    logic      minor_down;
    color_t    color;
  } cmd_t;

  // One plotted pixel.
  typedef struct packed {
    coord_t x;
    coord_t y;
    color_t color;
    logic   last;
  } pix_t;

endpackage

[rtl/blpg_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pixel generator front part
// Accepts request items, classifies them and prepares start items into the
// major/minor form of a line before they enter the command queue.
// ----------------------------------------------------------------------------
module blpg_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic                             req_type,
  input  blpg_pkg::coord_t                 start_x,
  input  blpg_pkg::coord_t                 start_y,
  input  blpg_pkg::coord_t                 end_x,
  input  blpg_pkg::coord_t                 end_y,
  input  blpg_pkg::color_t                 pen_color,
  input  logic [blpg_pkg::QCNT_BITS-1:0]   q_count,
  output logic                             q_wr,
  output blpg_pkg::cmd_t                   q_wdata
);
  import blpg_pkg::*;

  logic                 accept;
  logic [QCNT_BITS:0]   reserved;

  // Stage registers.
  logic   s1_v;
  logic   s1_req;
  coord_t s1_ax, s1_ay, s1_bx, s1_by;
  coord_t s1_dx, s1_dy;
  logic   s1_x_gt, s1_y_gt;
  color_t s1_color;

  // Stage two terms.
  logic   steep, swap, minor_gt;
  coord_t a_maj, b_maj, a_min, b_min, maj_d, min_d;

  // The queue must hold everything that may still arrive from the stage.
  assign reserved = {1'b0, q_count} + {{QCNT_BITS{1'b0}}, s1_v};
  assign full     = reserved >= (QCNT_BITS + 1)'(QDEPTH);
  assign accept   = push && !full;

  // Stage one: absolute deltas and endpoint order per axis.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= accept;
    end
    if (accept) begin
      s1_req   <= req_type;
      s1_ax    <= start_x;
      s1_ay    <= start_y;
      s1_bx    <= end_x;
      s1_by    <= end_y;
      s1_color <= pen_color;
      s1_x_gt  <= start_x > end_x;
      s1_y_gt  <= start_y > end_y;
      s1_dx    <= (start_x > end_x) ? (start_x - end_x) : (end_x - start_x);
      s1_dy    <= (start_y > end_y) ? (start_y - end_y) : (end_y - start_y);
    end
  end

  // Stage two: choose the major axis and order the endpoints along it.
  always_comb begin
    steep    = s1_dy > s1_dx;
    a_maj    = steep ? s1_ay : s1_ax;
    b_maj    = steep ? s1_by : s1_bx;
    a_min    = steep ? s1_ax : s1_ay;
    b_min    = steep ? s1_bx : s1_by;
    maj_d    = steep ? s1_dy : s1_dx;
    min_d    = steep ? s1_dx : s1_dy;
    swap     = steep ? s1_y_gt : s1_x_gt;
    minor_gt = steep ? s1_x_gt : s1_y_gt;

    q_wdata.kind        = (s1_req == REQ_START) ? CMD_START : CMD_STEP;
    q_wdata.steep       = steep;
    q_wdata.major_pos   = swap ? b_maj : a_maj;
    q_wdata.major_end   = swap ? a_maj : b_maj;
    q_wdata.minor_pos   = swap ? b_min : a_min;
    q_wdata.minor_delta = min_d;
    q_wdata.diff_delta  = maj_d - min_d;
    q_wdata.error       = maj_d >> 1;
    // The minor coordinate falls unless the first end lies strictly below the second.
    q_wdata.minor_down  = swap ? !minor_gt : (minor_gt || (min_d == '0));
    q_wdata.color       = s1_color;
  end

  assign q_wr = s1_v;

endmodule

[rtl/blpg_cmd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pixel generator command queue
// A short first-in first-out queue of prepared commands that lets the front
// and the back part stall independently.
// ----------------------------------------------------------------------------
module blpg_cmd_queue (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr,
  input  blpg_pkg::cmd_t                 wdata,
  input  logic                           rd,
  output blpg_pkg::cmd_t                 rdata,
  output logic                           valid,
  output logic [blpg_pkg::QCNT_BITS-1:0] count
);
  import blpg_pkg::*;

  cmd_t                 entries [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;

  assign valid = count != '0;
  assign rdata = entries[rd_ptr];

  // Pointer and fill count update.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

[rtl/blpg_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pixel generator back part
// Holds the active line, steps it one pixel per step command and buffers the
// plotted pixels for the result side.
// ----------------------------------------------------------------------------
module blpg_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  blpg_pkg::cmd_t   q_rdata,
  output logic             q_rd,
  output logic             empty,
  input  logic             pop,
  output blpg_pkg::coord_t pixel_x,
  output blpg_pkg::coord_t pixel_y,
  output blpg_pkg::color_t pixel_color,
  output logic             last_pixel
);
  import blpg_pkg::*;

  // Line state.
  logic   line_active;
  logic   steep_flag;
  coord_t major_pos, major_end, minor_pos;
  coord_t minor_delta, diff_delta, error_term;
  logic   minor_down;
  color_t held_color;

  // Result buffer.
  pix_t                   ob_entries [OBDEPTH];
  logic [OB_PTR_BITS-1:0] ob_wr_ptr;
  logic [OB_PTR_BITS-1:0] ob_rd_ptr;
  logic [OB_CNT_BITS-1:0] ob_count;

  logic   do_start, do_step, ob_pop;
  logic   last, err_neg;
  pix_t   pix_next;

  // Take a command whenever the result buffer has room.
  assign q_rd     = q_valid && (ob_count != (OB_CNT_BITS)'(OBDEPTH));
  assign do_start = q_rd && (q_rdata.kind == CMD_START);
  assign do_step  = q_rd && (q_rdata.kind == CMD_STEP) && line_active;
  assign ob_pop   = pop && !empty;

  // Pixel in screen axes and the error test.
  always_comb begin
    last           = major_pos == major_end;
    err_neg        = error_term < minor_delta;
    pix_next.x     = steep_flag ? minor_pos : major_pos;
    pix_next.y     = steep_flag ? major_pos : minor_pos;
    pix_next.color = held_color;
    pix_next.last  = last;
  end

  // Line state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (do_start) begin
      line_active <= 1'b1;
    end else if (do_step && last) begin
      line_active <= 1'b0;
    end
    if (do_start) begin
      steep_flag  <= q_rdata.steep;
      major_pos   <= q_rdata.major_pos;
      major_end   <= q_rdata.major_end;
      minor_pos   <= q_rdata.minor_pos;
      minor_delta <= q_rdata.minor_delta;
      diff_delta  <= q_rdata.diff_delta;
      error_term  <= q_rdata.error;
      minor_down  <= q_rdata.minor_down;
      held_color  <= q_rdata.color;
    end else if (do_step) begin
      if (err_neg) begin
        error_term <= error_term + diff_delta;
        minor_pos  <= minor_down ? (minor_pos - 1'b1) : (minor_pos + 1'b1);
      end else begin
        error_term <= error_term - minor_delta;
      end
      if (!last) begin
        major_pos <= major_pos + 1'b1;
      end
    end
  end

  // Result buffer pointers and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      ob_wr_ptr <= '0;
      ob_rd_ptr <= '0;
      ob_count  <= '0;
    end else begin
      if (do_step) begin
        ob_wr_ptr <= ob_wr_ptr + 1'b1;
      end
      if (ob_pop) begin
        ob_rd_ptr <= ob_rd_ptr + 1'b1;
      end
      if (do_step && !ob_pop) begin
        ob_count <= ob_count + 1'b1;
      end else if (ob_pop && !do_step) begin
        ob_count <= ob_count - 1'b1;
      end
    end
  end

  // Result buffer storage.
  always_ff @(posedge clk) begin
    if (do_step) begin
      ob_entries[ob_wr_ptr] <= pix_next;
    end
  end

  assign empty       = ob_count == '0;
  assign pixel_x     = ob_entries[ob_rd_ptr].x;
  assign pixel_y     = ob_entries[ob_rd_ptr].y;
  assign pixel_color = ob_entries[ob_rd_ptr].color;
  assign last_pixel  = ob_entries[ob_rd_ptr].last;

endmodule

[rtl/bresenham_line_pixel_generator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bresenham line pixel generator
// Integer line rasterizer: a start item sets up a line, each step item gives
// the next pixel of that line in screen axes.
//
//   Channel   Handshake        Payload
//   request   push / full      req_type, start_x, start_y, end_x, end_y, pen_color
//   pixel     pop / empty      pixel_x, pixel_y, pixel_color, last_pixel
//
// One item is taken every cycle while full is low; a step item's pixel reaches the
// result ports through the setup stage, the command queue and the back part
// stepping the queued command into the pixel buffer.
// The back part advances one command per cycle while the pixel buffer has room, set by its single error add.
// A stalled result side fills the two-entry pixel buffer, then the command
// queue, and raises full once the queue and the setup stage hold four commands.
// Synchronous reset empties both queues and drops the active line.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_generator_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic             req_type,
  input  blpg_pkg::coord_t start_x,
  input  blpg_pkg::coord_t start_y,
  input  blpg_pkg::coord_t end_x,
  input  blpg_pkg::coord_t end_y,
  input  blpg_pkg::color_t pen_color,
  output logic             empty,
  input  logic             pop,
  output blpg_pkg::coord_t pixel_x,
  output blpg_pkg::coord_t pixel_y,
  output blpg_pkg::color_t pixel_color,
  output logic             last_pixel
);
  import blpg_pkg::*;

  logic                 q_wr, q_rd, q_valid;
  cmd_t                 q_wdata, q_rdata;
  logic [QCNT_BITS-1:0] q_count;

  // Front part: transfer and setup.
  blpg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req_type  (req_type),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .pen_color (pen_color),
    .q_count   (q_count),
    .q_wr      (q_wr),
    .q_wdata   (q_wdata)
  );

  // Command queue between the parts.
  blpg_cmd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .rdata (q_rdata),
    .valid (q_valid),
    .count (q_count)
  );

  // Back part: line stepping and pixel buffer.
  blpg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_rdata     (q_rdata),
    .q_rd        (q_rd),
    .empty       (empty),
    .pop         (pop),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .last_pixel  (last_pixel)
  );

endmodule

[rtl/blpg_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pixel generator port checker
// Watches the top level ports: reset state, result holding and that no pixel
// appears without a step item to account for it.
// ----------------------------------------------------------------------------
module blpg_checker (
  input logic             clk,
  input logic             rst,
  input logic             push,
  input logic             full,
  input logic             req_type,
  input logic             empty,
  input logic             pop,
  input blpg_pkg::coord_t pixel_x,
  input blpg_pkg::coord_t pixel_y,
  input blpg_pkg::color_t pixel_color,
  input logic             last_pixel
);
  import blpg_pkg::*;

  logic                     step_in, pix_out;
  logic [INFLIGHT_BITS-1:0] credit;

  assign step_in = push && !full && (req_type == REQ_STEP);
  assign pix_out = pop && !empty;

  // Step items that may still owe a pixel, capped at what the block can hold.
  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else if (step_in && !pix_out) begin
      if (credit != (INFLIGHT_BITS)'(INFLIGHT_MAX)) begin
        credit <= credit + 1'b1;
      end
    end else if (pix_out && !step_in) begin
      credit <= credit - 1'b1;
    end
  end

  // Reset leaves both sides open and empty.
  a_reset_state: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("block not empty and ready after reset");

  // A waiting pixel stays until it is taken.
  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("pixel dropped without a transfer");

  // A stalled pixel keeps its payload.
  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> ($stable(pixel_x) && $stable(pixel_y) &&
                          $stable(pixel_color) && $stable(last_pixel)))
    else $error("stalled pixel changed");

  // Every pixel is owed to an earlier step item.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (credit != '0))
    else $error("pixel without a step item");

endmodule

bind bresenham_line_pixel_generator_unit blpg_checker u_checker (.*);
